FILE: design/pss_pkg.sv
// Package with the shared widths, register indexes and reset values of the source selector.
`default_nettype none
package pss_pkg;

  localparam int DEF_ID_WIDTH  = 8;
  localparam int DEF_DEV_WIDTH = 32;

  localparam int TIME_WIDTH      = 32;
  localparam int MARGIN_WIDTH    = 16;
  localparam int MARGIN_FRAC     = 8;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int CFG_INDEX_WIDTH = 1;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MARGIN_FACTOR = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_HOLD      = 1'd1;

  localparam logic [MARGIN_WIDTH-1:0] MARGIN_FACTOR_RESET = 16'd205;
  localparam logic [TIME_WIDTH-1:0]   MIN_HOLD_RESET      = 32'd1000;

endpackage
`default_nettype wire

FILE: design/position_source_selector_hysteresis.sv
// Best position source selection with hysteresis: round tracking, round-end decision, output word.
// A round's result word is registered from the round state when its last word leaves the input register.
// Throughput: one input word per cycle; the path from the input register through the
// running-minimum compare, the margin multiply and its compare into the result register sets it.
// Only a last word waits when the result register is full and stalled.
// Reset (rst, synchronous): no active source, no candidate, round state cleared,
// margin_factor = 205, min_hold_ms = 1000, both channels empty.
`default_nettype none
module position_source_selector_hysteresis #(
  parameter int ID_WIDTH  = pss_pkg::DEF_ID_WIDTH,
  parameter int DEV_WIDTH = pss_pkg::DEF_DEV_WIDTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [pss_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire logic [pss_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 has_entry,
  input  wire logic [ID_WIDTH-1:0]                  entry_id,
  input  wire logic                                 entry_eligible,
  input  wire logic signed [DEV_WIDTH-1:0]          entry_stddev,
  input  wire logic                                 round_last,
  input  wire logic [pss_pkg::TIME_WIDTH-1:0]       now_ms,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [ID_WIDTH-1:0]                       active_id,
  output logic                                      switched
);
  import pss_pkg::*;

  localparam int PROD_WIDTH = DEV_WIDTH + MARGIN_WIDTH;

  // Configuration registers
  logic [MARGIN_WIDTH-1:0] margin_factor;
  logic [TIME_WIDTH-1:0]   min_hold_ms;

  // Input register
  logic                  q_valid;
  logic                  q_has;
  logic [ID_WIDTH-1:0]   q_id;
  logic                  q_elig;
  logic [DEV_WIDTH-1:0]  q_dev;
  logic                  q_last;
  logic [TIME_WIDTH-1:0] q_now;

  // Persistent and per-round state
  logic [ID_WIDTH-1:0]   active_source;
  logic [ID_WIDTH-1:0]   candidate_source;
  logic [TIME_WIDTH-1:0] candidate_start;
  logic                  best_found;
  logic [ID_WIDTH-1:0]   best_id;
  logic [DEV_WIDTH-1:0]  best_dev;
  logic                  current_seen;
  logic                  current_ok;
  logic [DEV_WIDTH-1:0]  current_dev;

  // Round state after folding in the word held in the input register
  logic                  best_found_next;
  logic [ID_WIDTH-1:0]   best_id_next;
  logic [DEV_WIDTH-1:0]  best_dev_next;
  logic                  current_seen_next;
  logic                  current_ok_next;
  logic [DEV_WIDTH-1:0]  current_dev_next;

  logic [ID_WIDTH-1:0]   active_source_next;
  logic [ID_WIDTH-1:0]   candidate_source_next;
  logic [TIME_WIDTH-1:0] candidate_start_next;
  logic                  switched_next;

  logic                  advance;
  logic                  take_in;
  logic                  snap;
  logic                  usable;
  logic [DEV_WIDTH-1:0]  dev;
  logic                  usable_now;
  logic [PROD_WIDTH-1:0] lhs;
  logic [PROD_WIDTH-1:0] rhs;
  logic                  beats_margin;
  logic [TIME_WIDTH-1:0] held;

  // A last word may only move on when the result register can take its word.
  assign advance  = q_valid && (!q_last || !out_valid || !out_stall);
  assign in_stall = q_valid && !advance;
  assign take_in  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      margin_factor <= MARGIN_FACTOR_RESET;
      min_hold_ms   <= MIN_HOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MARGIN_FACTOR: margin_factor <= cfg_data[MARGIN_WIDTH-1:0];
        REG_MIN_HOLD:      min_hold_ms   <= cfg_data[TIME_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (take_in) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      q_has  <= has_entry;
      q_id   <= entry_id;
      q_elig <= entry_eligible;
      q_dev  <= entry_stddev;
      q_last <= round_last;
      q_now  <= now_ms;
    end
  end

  // Snapshot tracking: first match of the active id and running minimum.
  always_comb begin
    snap   = q_has && (q_id != '0);
    usable = q_elig && !q_dev[DEV_WIDTH-1];
    dev    = usable ? q_dev : '0;

    current_seen_next = current_seen;
    current_ok_next   = current_ok;
    current_dev_next  = current_dev;
    if (snap && !current_seen && (q_id == active_source)) begin
      current_seen_next = 1'b1;
      current_ok_next   = usable;
      current_dev_next  = dev;
    end

    best_found_next = best_found;
    best_id_next    = best_id;
    best_dev_next   = best_dev;
    if (snap && usable &&
        (!best_found || (dev < best_dev) || ((dev == best_dev) && (q_id < best_id)))) begin
      best_found_next = 1'b1;
      best_id_next    = q_id;
      best_dev_next   = dev;
    end
  end

  // Round-end decision.
  always_comb begin
    usable_now   = (active_source != '0) && current_seen_next && current_ok_next;
    lhs          = {{(MARGIN_WIDTH-MARGIN_FRAC){1'b0}}, best_dev_next, {MARGIN_FRAC{1'b0}}};
    rhs          = PROD_WIDTH'(current_dev_next) * PROD_WIDTH'(margin_factor);
    beats_margin = lhs < rhs;
    held         = q_now - candidate_start;

    active_source_next    = active_source;
    candidate_source_next = '0;
    candidate_start_next  = candidate_start;
    switched_next         = 1'b0;

    if (!usable_now) begin
      active_source_next = best_found_next ? best_id_next : '0;
      switched_next      = best_found_next && (best_id_next != '0) &&
                           (best_id_next != active_source);
    end else if (best_found_next && (best_id_next != active_source) && beats_margin) begin
      if (candidate_source != best_id_next) begin
        candidate_source_next = best_id_next;
        candidate_start_next  = q_now;
      end else if (held >= min_hold_ms) begin
        active_source_next = best_id_next;
        switched_next      = 1'b1;
      end else begin
        candidate_source_next = candidate_source;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_source    <= '0;
      candidate_source <= '0;
      candidate_start  <= '0;
      best_found       <= 1'b0;
      best_id          <= '0;
      best_dev         <= '0;
      current_seen     <= 1'b0;
      current_ok       <= 1'b0;
      current_dev      <= '0;
    end else if (advance) begin
      if (q_last) begin
        active_source    <= active_source_next;
        candidate_source <= candidate_source_next;
        candidate_start  <= candidate_start_next;
        best_found       <= 1'b0;
        best_id          <= '0;
        best_dev         <= '0;
        current_seen     <= 1'b0;
        current_ok       <= 1'b0;
        current_dev      <= '0;
      end else begin
        best_found   <= best_found_next;
        best_id      <= best_id_next;
        best_dev     <= best_dev_next;
        current_seen <= current_seen_next;
        current_ok   <= current_ok_next;
        current_dev  <= current_dev_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && q_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && q_last) begin
      active_id <= active_source_next;
      switched  <= switched_next;
    end
  end

`ifndef SYNTH
  a_cand_not_active: assert property (@(posedge clk) disable iff (rst)
    (candidate_source != '0) |-> (candidate_source != active_source))
    else $error("candidate equals the active source");

  a_switch_has_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && switched) |-> (active_id != '0))
    else $error("switch reported without a source");

  a_best_clean: assert property (@(posedge clk) disable iff (rst)
    !best_found |-> ((best_id == '0) && (best_dev == '0)))
    else $error("best source held without a find");

  a_word_from_last: assert property (@(posedge clk) disable iff (rst)
    (advance && q_last) |=> (out_valid && (active_id == active_source)))
    else $error("round end did not load the result word");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (q_valid && q_last && out_valid && out_stall))
    else $error("input stalled without a full result register");
`endif

endmodule
`default_nettype wire
